// ----- rtl/mlfq_pkg.sv -----
`timescale 1ns / 1ps

package mlfq_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int ID_W      = 5;
    localparam int PCT_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int LEVEL_W   = 2;
    localparam int TIME_W    = 30;
    localparam int QUANT_W   = 27;
    localparam int MAP_MAX   = 32;

    // Ready queues: round robin plus three feedback levels
    localparam int NUM_FIFOS = 4;
    localparam int FIFO_QW   = 2;

    // Burst arithmetic: quantum / 100 as (quantum * RECIP_MUL) >> RECIP_SHIFT,
    // exact for any quantum below 2^30
    localparam int PCT_DIVISOR = 100;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd42949673;
    localparam int ACC_W       = 28;
    localparam int MUL_STEPS   = PCT_W;
    localparam int STEP_W      = 3;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 27'd10000000;
    localparam logic [TIME_W-1:0]  TIME_MAX      = 30'h3FFF_FFFF;
    localparam logic [PCT_W-1:0]   PCT_FULL      = 8'd100;

    // Request codes
    localparam logic [FUNC_W-1:0] FN_ADMIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SELECT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REPORT = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADMITTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNBLOCKED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE_RES   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REQUEUED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BLOCKED    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_TERMINATED = 3'd7;

    // Queue levels
    localparam logic [LEVEL_W-1:0] LVL_RR = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_1  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_2  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_3  = 2'd3;

    // Configuration register byte addresses
    localparam logic [1:0] ADDR_BASE_QUANTUM = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIFO_RD,
        S_MUL,
        S_EXEC
    } state_t;

    typedef enum logic [2:0] {
        OP_ADMIT,
        OP_UNBLOCK,
        OP_DISPATCH,
        OP_IDLE,
        OP_REPORT,
        OP_BAD_ID
    } op_t;

    // Lowest set bit of a map: {found, index}
    function automatic logic [ID_W:0] lowest_set(input logic [MAP_MAX-1:0] map);
        logic [ID_W:0] res;
        res = '0;
        for (int i = MAP_MAX - 1; i >= 0; i--)
        begin
            if (map[i])
            begin
                res = {1'b1, ID_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/mlfq_in_if.sv -----
`timescale 1ns / 1ps

interface mlfq_in_if;
    import mlfq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic                      realtime_req;
    logic [ID_W-1:0]           task_id;
    logic signed [PCT_W-1:0]   percent_used;

    modport source (output valid, func, realtime_req, task_id, percent_used, input ready);
    modport sink   (input valid, func, realtime_req, task_id, percent_used, output ready);
endinterface

// ----- rtl/mlfq_out_if.sv -----
`timescale 1ns / 1ps

interface mlfq_out_if;
    import mlfq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       task_out;
    logic [LEVEL_W-1:0]    level_out;
    logic [TIME_W-1:0]     slice_ns;
    logic [TIME_W-1:0]     burst_ns;

    modport source (output valid, status, task_out, level_out, slice_ns, burst_ns, input ready);
    modport sink   (input valid, status, task_out, level_out, slice_ns, burst_ns, output ready);
endinterface

// ----- rtl/mlfq_process_scheduler_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      func, realtime_req, task_id, percent_used
// out_ch    out  valid/ready      status, task_out, level_out, slice_ns, burst_ns
// apb       in   psel/penable     paddr, pwrite, pwdata -> prdata, pready
//
// One request at a time. Admit, unblock, idle and bad id go from decode straight to
// exec; dispatch reads queue memory, then level memory, before exec; report does
// quantum/100 by reciprocal multiply in decode, then an 8-step shift-add multiply
// by |percent| on the adder. Ready rises at the edge that loads the result.
// Reset frees all ids and clears the blocked map, queue pointers and counts, not the queue and level memories.
// A stalled result holds in the output register; the next request waits at commit.

module mlfq_process_scheduler_core #(
    parameter int NUM_TASKS = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    mlfq_in_if.sink            in_ch,
    mlfq_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mlfq_pkg::*;

    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int FIFO_DEPTH = NUM_FIFOS << IDX_W;
    localparam int FIFO_AW   = FIFO_QW + IDX_W;
    localparam int PROD_W    = QUANT_W + RECIP_W;

    localparam logic [IDX_W-1:0] PTR_LAST  = IDX_W'(NUM_TASKS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_TASKS);
    localparam logic [ID_W:0]    ID_LIMIT  = (ID_W + 1)'(NUM_TASKS);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);

    // Control state
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [QUANT_W-1:0]     bq_reg, bq_next;
    logic [NUM_TASKS-1:0]   free_map_reg, free_map_next;
    logic [NUM_TASKS-1:0]   blocked_map_reg, blocked_map_next;
    logic [IDX_W-1:0]       head_reg [NUM_FIFOS];
    logic [IDX_W-1:0]       head_next [NUM_FIFOS];
    logic [IDX_W-1:0]       tail_reg [NUM_FIFOS];
    logic [IDX_W-1:0]       tail_next [NUM_FIFOS];
    logic [CNT_W-1:0]       count_reg [NUM_FIFOS];
    logic [CNT_W-1:0]       count_next [NUM_FIFOS];
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    // Request and working payload
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic                   rt_reg, rt_next;
    logic [ID_W-1:0]        tid_reg, tid_next;
    logic [PCT_W-1:0]       pct_reg, pct_next;
    logic [ID_W-1:0]        sel_id_reg, sel_id_next;
    logic [FIFO_QW-1:0]     sel_q_reg, sel_q_next;
    logic [QUANT_W-1:0]     quo_reg, quo_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [PCT_W-1:0]       mag_reg, mag_next;

    // Result register
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [ID_W-1:0]        task_reg, task_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [TIME_W-1:0]      slice_reg, slice_next;
    logic [TIME_W-1:0]      burst_reg, burst_next;

    // Memories
    logic [LEVEL_W-1:0]     lvl_mem [NUM_TASKS];
    logic [LEVEL_W-1:0]     lvl_rdata_reg;
    logic                   lvl_rd_en;
    logic [IDX_W-1:0]       lvl_raddr;
    logic                   lvl_we;
    logic [IDX_W-1:0]       lvl_waddr;
    logic [LEVEL_W-1:0]     lvl_wdata;

    logic [ID_W-1:0]        fifo_mem [FIFO_DEPTH];
    logic [ID_W-1:0]        fifo_rdata_reg;
    logic                   fifo_rd_en;
    logic [FIFO_AW-1:0]     fifo_raddr;
    logic                   fifo_we;
    logic [FIFO_AW-1:0]     fifo_waddr;
    logic [ID_W-1:0]        fifo_wdata;

    // Multiply-step adder and quantum reciprocal product
    logic [ACC_W-1:0]       alu_a;
    logic [ACC_W-1:0]       alu_b;
    logic [ACC_W-1:0]       alu_sum;
    logic [PROD_W-1:0]      recip_prod;

    // Misc combinational
    logic                   cfg_wr;
    logic                   commit;
    logic                   push_en;
    logic [FIFO_QW-1:0]     push_q;
    logic [ID_W-1:0]        push_id;
    logic [ID_W:0]          free_pick;
    logic [ID_W:0]          blk_pick;
    logic                   q_found;
    logic [FIFO_QW-1:0]     q_pick;
    logic [TIME_W:0]        burst_wide;
    logic [TIME_W-1:0]      burst_sat;
    logic [LEVEL_W-1:0]     lv_new;
    logic                   pct_neg;

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BASE_QUANTUM);
    assign prdata = (paddr == ADDR_BASE_QUANTUM) ? {{(32 - QUANT_W){1'b0}}, bq_reg} : '0;
    assign bq_next = cfg_wr ? pwdata[QUANT_W-1:0] : bq_reg;

    // Channel outputs
    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = status_reg;
    assign out_ch.task_out  = task_reg;
    assign out_ch.level_out = level_reg;
    assign out_ch.slice_ns  = slice_reg;
    assign out_ch.burst_ns  = burst_reg;

    // Priority searches over maps and queue counts
    assign free_pick = lowest_set(MAP_MAX'(free_map_reg));
    assign blk_pick  = lowest_set(MAP_MAX'(blocked_map_reg));

    always_comb
    begin
        q_found = 1'b0;
        q_pick  = '0;
        for (int q = NUM_FIFOS - 1; q >= 0; q--)
        begin
            if (count_reg[q] != '0)
            begin
                q_found = 1'b1;
                q_pick  = FIFO_QW'(q);
            end
        end
    end

    // Quantum divided by 100 through its reciprocal
    assign recip_prod = {{RECIP_W{1'b0}}, bq_reg} * {{QUANT_W{1'b0}}, RECIP_MUL};

    // Adder: shift-add multiply step, multiplier MSB first
    assign alu_a   = {acc_reg[ACC_W-2:0], 1'b0};
    assign alu_b   = mag_reg[PCT_W-1] ? ACC_W'(quo_reg) : '0;
    assign alu_sum = alu_a + alu_b;

    // Burst: scaled product, saturated
    assign burst_wide = (TIME_W + 1)'(acc_reg) << lvl_rdata_reg;
    assign burst_sat  = burst_wide[TIME_W] ? TIME_MAX : burst_wide[TIME_W-1:0];
    assign pct_neg    = pct_reg[PCT_W-1];

    // Level after a report
    always_comb
    begin
        if (!pct_neg && (pct_reg == PCT_FULL))
        begin
            lv_new = ((lvl_rdata_reg == LVL_1) || (lvl_rdata_reg == LVL_2))
                   ? lvl_rdata_reg + LVL_1 : lvl_rdata_reg;
        end
        else if (pct_neg)
        begin
            lv_new = (lvl_rdata_reg != LVL_RR) ? LVL_1 : LVL_RR;
        end
        else
        begin
            lv_new = lvl_rdata_reg;
        end
    end

    assign commit = (state_reg == S_EXEC) && (!out_valid_reg || out_ch.ready);

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        free_map_next    = free_map_reg;
        blocked_map_next = blocked_map_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        func_next        = func_reg;
        rt_next          = rt_reg;
        tid_next         = tid_reg;
        pct_next         = pct_reg;
        sel_id_next      = sel_id_reg;
        sel_q_next       = sel_q_reg;
        quo_next         = quo_reg;
        acc_next         = acc_reg;
        mag_next         = mag_reg;
        status_next      = status_reg;
        task_next        = task_reg;
        level_next       = level_reg;
        slice_next       = slice_reg;
        burst_next       = burst_reg;
        lvl_rd_en        = 1'b0;
        lvl_raddr        = '0;
        lvl_we           = 1'b0;
        lvl_waddr        = '0;
        lvl_wdata        = '0;
        fifo_rd_en       = 1'b0;
        fifo_raddr       = '0;
        push_en          = 1'b0;
        push_q           = '0;
        push_id          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a request
                if (in_ch.valid)
                begin
                    func_next = in_ch.func;
                    rt_next   = in_ch.realtime_req;
                    tid_next  = in_ch.task_id;
                    pct_next  = in_ch.percent_used;
                    if (in_ch.func != FN_NONE)
                    begin
                        state_next = S_DECODE;
                    end
                end
            end

            S_DECODE:
            begin
                unique case (func_reg)
                    FN_ADMIT:
                    begin
                        op_next    = OP_ADMIT;
                        state_next = S_EXEC;
                    end
                    FN_SELECT:
                    begin
                        if (blk_pick[ID_W])
                        begin
                            // Release lowest blocked id, fetch its level
                            op_next     = OP_UNBLOCK;
                            sel_id_next = blk_pick[ID_W-1:0];
                            lvl_rd_en   = 1'b1;
                            lvl_raddr   = blk_pick[IDX_W-1:0];
                            state_next  = S_EXEC;
                        end
                        else if (q_found)
                        begin
                            // Read head of the first non-empty queue
                            op_next    = OP_DISPATCH;
                            sel_q_next = q_pick;
                            fifo_rd_en = 1'b1;
                            fifo_raddr = {q_pick, head_reg[q_pick]};
                            state_next = S_FIFO_RD;
                        end
                        else
                        begin
                            op_next    = OP_IDLE;
                            state_next = S_EXEC;
                        end
                    end
                    default:
                    begin
                        if ({1'b0, tid_reg} >= ID_LIMIT)
                        begin
                            op_next    = OP_BAD_ID;
                            state_next = S_EXEC;
                        end
                        else
                        begin
                            // Fetch level, latch quantum / 100, start the multiply
                            op_next    = OP_REPORT;
                            lvl_rd_en  = 1'b1;
                            lvl_raddr  = tid_reg[IDX_W-1:0];
                            quo_next   = QUANT_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);
                            acc_next   = '0;
                            step_next  = '0;
                            mag_next   = pct_reg[PCT_W-1] ? (~pct_reg + PCT_W'(1)) : pct_reg;
                            state_next = S_MUL;
                        end
                    end
                endcase
            end

            S_FIFO_RD:
            begin
                // Dispatched id is known, fetch its level
                sel_id_next = fifo_rdata_reg;
                lvl_rd_en   = 1'b1;
                lvl_raddr   = fifo_rdata_reg[IDX_W-1:0];
                state_next  = S_EXEC;
            end

            S_MUL:
            begin
                // One multiplier bit per cycle, MSB first
                acc_next = alu_sum;
                mag_next = {mag_reg[PCT_W-2:0], 1'b0};
                if (step_reg == MUL_LAST)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            S_EXEC:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    status_next    = ST_IDLE_RES;
                    task_next      = '0;
                    level_next     = LVL_RR;
                    slice_next     = '0;
                    burst_next     = '0;
                    unique case (op_reg)
                        OP_ADMIT:
                        begin
                            if (free_pick[ID_W])
                            begin
                                free_map_next[free_pick[IDX_W-1:0]] = 1'b0;
                                lvl_we      = 1'b1;
                                lvl_waddr   = free_pick[IDX_W-1:0];
                                lvl_wdata   = rt_reg ? LVL_RR : LVL_1;
                                push_en     = 1'b1;
                                push_q      = rt_reg ? LVL_RR : LVL_1;
                                push_id     = free_pick[ID_W-1:0];
                                status_next = ST_ADMITTED;
                                task_next   = free_pick[ID_W-1:0];
                                level_next  = rt_reg ? LVL_RR : LVL_1;
                            end
                            else
                            begin
                                status_next = ST_NO_FREE;
                            end
                        end
                        OP_UNBLOCK:
                        begin
                            blocked_map_next[sel_id_reg[IDX_W-1:0]] = 1'b0;
                            push_en     = 1'b1;
                            push_q      = (lvl_rdata_reg == LVL_RR) ? LVL_RR : LVL_1;
                            push_id     = sel_id_reg;
                            status_next = ST_UNBLOCKED;
                            task_next   = sel_id_reg;
                            level_next  = (lvl_rdata_reg == LVL_RR) ? LVL_RR : LVL_1;
                        end
                        OP_DISPATCH:
                        begin
                            // Pop the queue head
                            head_next[sel_q_reg]  = (head_reg[sel_q_reg] == PTR_LAST)
                                                  ? '0 : head_reg[sel_q_reg] + IDX_W'(1);
                            count_next[sel_q_reg] = count_reg[sel_q_reg] - CNT_W'(1);
                            status_next = ST_DISPATCHED;
                            task_next   = sel_id_reg;
                            level_next  = lvl_rdata_reg;
                            slice_next  = TIME_W'(bq_reg) << lvl_rdata_reg;
                        end
                        OP_IDLE:
                        begin
                            status_next = ST_IDLE_RES;
                        end
                        OP_REPORT:
                        begin
                            task_next  = tid_reg;
                            burst_next = burst_sat;
                            level_next = lv_new;
                            if (!pct_neg && (pct_reg == PCT_FULL))
                            begin
                                lvl_we      = 1'b1;
                                lvl_waddr   = tid_reg[IDX_W-1:0];
                                lvl_wdata   = lv_new;
                                push_en     = 1'b1;
                                push_q      = lv_new;
                                push_id     = tid_reg;
                                status_next = ST_REQUEUED;
                            end
                            else if (pct_neg)
                            begin
                                lvl_we      = 1'b1;
                                lvl_waddr   = tid_reg[IDX_W-1:0];
                                lvl_wdata   = lv_new;
                                blocked_map_next[tid_reg[IDX_W-1:0]] = 1'b1;
                                status_next = ST_BLOCKED;
                            end
                            else
                            begin
                                free_map_next[tid_reg[IDX_W-1:0]] = 1'b1;
                                status_next = ST_TERMINATED;
                            end
                        end
                        OP_BAD_ID:
                        begin
                            status_next = ST_TERMINATED;
                            task_next   = tid_reg;
                        end
                        default:
                        begin
                            status_next = ST_IDLE_RES;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Enqueue, dropped when the queue is full
        fifo_we    = 1'b0;
        fifo_waddr = {push_q, tail_reg[push_q]};
        fifo_wdata = push_id;
        if (push_en && (count_reg[push_q] < CNT_FULL))
        begin
            fifo_we            = 1'b1;
            tail_next[push_q]  = (tail_reg[push_q] == PTR_LAST)
                               ? '0 : tail_reg[push_q] + IDX_W'(1);
            count_next[push_q] = count_reg[push_q] + CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_IDLE;
            bq_reg          <= QUANTUM_RESET;
            free_map_reg    <= '1;
            blocked_map_reg <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int q = 0; q < NUM_FIFOS; q++)
            begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            bq_reg          <= bq_next;
            free_map_reg    <= free_map_next;
            blocked_map_reg <= blocked_map_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        rt_reg     <= rt_next;
        tid_reg    <= tid_next;
        pct_reg    <= pct_next;
        sel_id_reg <= sel_id_next;
        sel_q_reg  <= sel_q_next;
        quo_reg    <= quo_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        status_reg <= status_next;
        task_reg   <= task_next;
        level_reg  <= level_next;
        slice_reg  <= slice_next;
        burst_reg  <= burst_next;
    end

    // Level memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        if (lvl_rd_en)
        begin
            lvl_rdata_reg <= lvl_mem[lvl_raddr];
        end
    end

    // Ready queue memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (fifo_rd_en)
        begin
            fifo_rdata_reg <= fifo_mem[fifo_raddr];
        end
    end

endmodule
